/* rtl/thick_line_span_rasterizer_assert.svh */
// Assertion macros used by the thick line span rasterizer top level.
`ifndef THICK_LINE_SPAN_RASTERIZER_ASSERT_SVH
`define THICK_LINE_SPAN_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define TLSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define TLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tlsr_pkg.sv */
// Shared types and constants of the thick line span rasterizer.
package tlsr_pkg;

  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 8;
  localparam int COLOR_W  = 32;
  localparam int SCREEN_W = 13;
  localparam int LEN_W    = RADIUS_W + 1;
  localparam int SPOS_W   = COORD_W + 2;
  localparam int CFG_IDX_W = 1;

  // Action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX   = 13'd4096;
  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd600;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd1024;

  // Classified command, front to back
  typedef struct packed {
    logic                is_start;
    logic                refused;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  dmaj;
    logic [COORD_W-1:0]  dmin;
    logic                major_x;
    logic [1:0]          dirs;     // bit0 x steps down, bit1 y steps down
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  color;
  } cmd_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Unclipped span, back to clip stage
  typedef struct packed {
    logic signed [SPOS_W-1:0] sx;
    logic signed [SPOS_W-1:0] sy;
    logic [LEN_W-1:0]         len;
    logic [COLOR_W-1:0]       color;
    logic                     last;
  } span_t;

  // Back end status
  typedef struct packed {
    logic busy;
    logic load;
    logic load_last;
  } back_stat_t;

endpackage

/* rtl/tlsr_front.sv */
// Front end: classifies an incoming item and prepares the line setup.
module tlsr_front (
  input  logic                          action,
  input  logic [tlsr_pkg::COORD_W-1:0]  start_x,
  input  logic [tlsr_pkg::COORD_W-1:0]  start_y,
  input  logic [tlsr_pkg::COORD_W-1:0]  end_x,
  input  logic [tlsr_pkg::COORD_W-1:0]  end_y,
  input  logic [tlsr_pkg::RADIUS_W-1:0] brush_radius,
  input  logic [tlsr_pkg::COLOR_W-1:0]  line_color,
  output tlsr_pkg::cmd_t                cmd
);

  logic                         x_fwd, y_fwd;
  logic [tlsr_pkg::COORD_W-1:0] dx, dy, r_ext;

  always_comb begin
    x_fwd = end_x > start_x;
    y_fwd = end_y > start_y;
    dx    = x_fwd ? end_x - start_x : start_x - end_x;
    dy    = y_fwd ? end_y - start_y : start_y - end_y;
    r_ext = tlsr_pkg::COORD_W'(brush_radius);

    cmd.is_start = (action == tlsr_pkg::ACT_START);
    // zero brush or any endpoint closer to the edge than the brush
    cmd.refused  = (brush_radius == '0) || (start_x < r_ext) || (end_x < r_ext) ||
                   (start_y < r_ext) || (end_y < r_ext);
    cmd.px       = start_x;
    cmd.py       = start_y;
    cmd.major_x  = dx >= dy;
    cmd.dmaj     = (dx >= dy) ? dx : dy;
    cmd.dmin     = (dx >= dy) ? dy : dx;
    cmd.dirs     = {~y_fwd, ~x_fwd};
    cmd.radius   = brush_radius;
    cmd.color    = line_color;
  end

endmodule

/* rtl/tlsr_queue.sv */
// Short command queue between the front and back ends.
module tlsr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  tlsr_pkg::cmd_t     wr_data,
  input  logic               rd_en,
  output tlsr_pkg::cmd_t     rd_data,
  output tlsr_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlsr_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* rtl/tlsr_back.sv */
// Back end: Bresenham walk, midpoint circle rows and span generation.
module tlsr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlsr_pkg::q_stat_t    q_stat,
  input  tlsr_pkg::cmd_t       cmd,
  input  logic                 take,
  output logic                 pop,
  output logic                 span_valid,
  output tlsr_pkg::span_t      span,
  output tlsr_pkg::back_stat_t stat
);

  localparam int CW    = tlsr_pkg::COORD_W;
  localparam int RW    = tlsr_pkg::RADIUS_W;
  localparam int SW    = tlsr_pkg::SPOS_W;
  localparam int LERR_W = CW + 3;
  localparam int CERR_W = RW + 3;

  // Span slot order within one circle row
  localparam logic [1:0] SLOT_LOW_WIDE    = 2'd0;
  localparam logic [1:0] SLOT_HIGH_NARROW = 2'd1;
  localparam logic [1:0] SLOT_HIGH_WIDE   = 2'd2;
  localparam logic [1:0] SLOT_LOW_NARROW  = 2'd3;

  logic                         busy_r, busy_nxt;
  logic                         a_valid_r, a_valid_nxt;
  logic [CW-1:0]                px_r, px_nxt, py_r, py_nxt;
  logic signed [LERR_W-1:0]     lerr_r, lerr_nxt;
  logic [CW-1:0]                steps_r, steps_nxt;
  logic [CW-1:0]                dmaj_r, dmaj_nxt, dmin_r, dmin_nxt;
  logic                         major_x_r, major_x_nxt;
  logic [1:0]                   dirs_r, dirs_nxt;
  logic [RW-1:0]                cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CERR_W-1:0]     cerr_r, cerr_nxt;
  logic [1:0]                   slot_r, slot_nxt;
  logic [RW-1:0]                rad_r, rad_nxt;
  logic [tlsr_pkg::COLOR_W-1:0] color_r, color_nxt;
  tlsr_pkg::span_t              span_r, span_nxt;

  logic                     go, req, odd, y_sub, first_row, row_end;
  logic                     cerr_neg, circ_done, lerr_pos, last;
  logic [RW-1:0]            off_x, off_y, cy1, cx1;
  logic [tlsr_pkg::LEN_W-1:0] len;
  logic signed [SW-1:0]     sx, sy, px_s, py_s;
  logic signed [CERR_W-1:0] cerr_a, cerr_b, cerr_init;
  logic signed [LERR_W-1:0] two_dmin, two_dmaj, lerr_step, lerr_init;
  logic [CW-1:0]            px_step, py_step;

  // Handshake with queue and span register
  always_comb begin
    go  = !q_stat.empty && (!a_valid_r || take);
    req = go && !cmd.is_start && busy_r;
  end

  // Current span before clipping
  always_comb begin
    odd   = slot_r[0];
    y_sub = (slot_r == SLOT_HIGH_NARROW) || (slot_r == SLOT_HIGH_WIDE);
    len   = odd ? {cy_r, 1'b0} : {cx_r, 1'b0};
    off_x = odd ? cy_r : cx_r;
    off_y = odd ? cx_r : cy_r;
    px_s  = signed'(SW'(px_r));
    py_s  = signed'(SW'(py_r));
    sx    = px_s - signed'(SW'(off_x));
    sy    = y_sub ? py_s - signed'(SW'(off_y)) : py_s + signed'(SW'(off_y));
  end

  // Circle row step; odd slots of the first row are empty and skipped
  always_comb begin
    first_row = (cy_r == '0);
    row_end   = (slot_r == SLOT_LOW_NARROW) || ((slot_r == SLOT_HIGH_WIDE) && first_row);
    cy1       = cy_r + 1'b1;
    cerr_neg  = cerr_r[CERR_W-1];
    cerr_a    = cerr_r + signed'(CERR_W'({cy_r, 1'b0})) + signed'(CERR_W'(3));
    cerr_b    = cerr_r + signed'(CERR_W'({cy_r, 1'b0})) - signed'(CERR_W'({cx_r, 1'b0}))
                + signed'(CERR_W'(6));
    cx1       = cerr_neg ? cx_r : cx_r - 1'b1;
    circ_done = cerr_neg ? ({1'b0, cx_r} <= {1'b0, cy_r})
                         : ({1'b0, cx_r} <= ({1'b0, cy_r} + 1'b1));
    last      = row_end && circ_done && (steps_r == '0);
  end

  // Line step
  always_comb begin
    two_dmin  = signed'(LERR_W'({dmin_r, 1'b0}));
    two_dmaj  = signed'(LERR_W'({dmaj_r, 1'b0}));
    lerr_pos  = !lerr_r[LERR_W-1] && (lerr_r != '0);
    lerr_step = lerr_pos ? lerr_r + two_dmin - two_dmaj : lerr_r + two_dmin;
    px_step   = dirs_r[0] ? px_r - 1'b1 : px_r + 1'b1;
    py_step   = dirs_r[1] ? py_r - 1'b1 : py_r + 1'b1;
    lerr_init = signed'(LERR_W'({cmd.dmin, 1'b0})) - signed'(LERR_W'(cmd.dmaj));
    cerr_init = signed'(CERR_W'(1)) - signed'(CERR_W'(cmd.radius));
  end

  // Next state
  always_comb begin
    busy_nxt    = busy_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    lerr_nxt    = lerr_r;
    steps_nxt   = steps_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    major_x_nxt = major_x_r;
    dirs_nxt    = dirs_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cerr_nxt    = cerr_r;
    slot_nxt    = slot_r;
    rad_nxt     = rad_r;
    color_nxt   = color_r;
    span_nxt    = span_r;
    a_valid_nxt = a_valid_r;

    if (take) begin
      a_valid_nxt = 1'b0;
    end

    if (go && cmd.is_start) begin
      // new line drops the current one
      busy_nxt    = !cmd.refused;
      rad_nxt     = cmd.radius;
      color_nxt   = cmd.color;
      px_nxt      = cmd.px;
      py_nxt      = cmd.py;
      dmaj_nxt    = cmd.dmaj;
      dmin_nxt    = cmd.dmin;
      major_x_nxt = cmd.major_x;
      dirs_nxt    = cmd.dirs;
      lerr_nxt    = lerr_init;
      steps_nxt   = cmd.dmaj;
      cx_nxt      = cmd.radius;
      cy_nxt      = '0;
      cerr_nxt    = cerr_init;
      slot_nxt    = SLOT_LOW_WIDE;
    end else if (req) begin
      a_valid_nxt    = 1'b1;
      span_nxt.sx    = sx;
      span_nxt.sy    = sy;
      span_nxt.len   = len;
      span_nxt.color = color_r;
      span_nxt.last  = last;

      if (!row_end) begin
        slot_nxt = ((slot_r == SLOT_LOW_WIDE) && first_row) ? SLOT_HIGH_WIDE
                                                            : slot_r + 1'b1;
      end else begin
        slot_nxt = SLOT_LOW_WIDE;
        if (!circ_done) begin
          cx_nxt   = cx1;
          cy_nxt   = cy1;
          cerr_nxt = cerr_neg ? cerr_a : cerr_b;
        end else if (steps_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          // next line point, restart the brush circle
          lerr_nxt  = lerr_step;
          px_nxt    = (major_x_r || lerr_pos) ? px_step : px_r;
          py_nxt    = (!major_x_r || lerr_pos) ? py_step : py_r;
          steps_nxt = steps_r - 1'b1;
          cx_nxt    = rad_r;
          cy_nxt    = '0;
          cerr_nxt  = signed'(CERR_W'(1)) - signed'(CERR_W'(rad_r));
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  // Walk state and span payload
  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    lerr_r    <= lerr_nxt;
    steps_r   <= steps_nxt;
    dmaj_r    <= dmaj_nxt;
    dmin_r    <= dmin_nxt;
    major_x_r <= major_x_nxt;
    dirs_r    <= dirs_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cerr_r    <= cerr_nxt;
    slot_r    <= slot_nxt;
    rad_r     <= rad_nxt;
    color_r   <= color_nxt;
    span_r    <= span_nxt;
  end

  assign pop            = go;
  assign span_valid     = a_valid_r;
  assign span           = span_r;
  assign stat.busy      = busy_r;
  assign stat.load      = req;
  assign stat.load_last = last;

endmodule

/* rtl/tlsr_clip.sv */
// Output stage: clips a span to the screen and holds it for the consumer.
module tlsr_clip (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           span_valid,
  input  tlsr_pkg::span_t                span,
  input  logic [tlsr_pkg::SCREEN_W-1:0]  scr_w,
  input  logic [tlsr_pkg::SCREEN_W-1:0]  scr_h,
  output logic                           take,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [tlsr_pkg::COORD_W-1:0]   out_sx,
  output logic [tlsr_pkg::COORD_W-1:0]   out_ex,
  output logic [tlsr_pkg::COORD_W-1:0]   out_sy,
  output logic [tlsr_pkg::COLOR_W-1:0]   out_color,
  output logic                           out_last
);

  localparam int PW = tlsr_pkg::SPOS_W + 1;
  localparam int CW = tlsr_pkg::COORD_W;

  logic                         valid_r, valid_nxt;
  logic [CW-1:0]                sx_r, sx_nxt, ex_r, ex_nxt, sy_r, sy_nxt;
  logic [tlsr_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                         last_r, last_nxt;

  logic signed [PW-1:0] w_s, h_s, sx_s, sy_s, len_s, sum, shifted;
  logic signed [PW-1:0] sx1, sx2, ex_n, ex_cap, sy1;
  logic                 over;

  assign take = span_valid && (!valid_r || !out_stall);

  // Right edge shift, left saturation, end cap, top and bottom clamp
  always_comb begin
    w_s     = signed'(PW'(scr_w));
    h_s     = signed'(PW'(scr_h));
    sx_s    = PW'(span.sx);
    sy_s    = PW'(span.sy);
    len_s   = signed'(PW'(span.len));
    sum     = sx_s + len_s;
    shifted = w_s - len_s;
    over    = sum > w_s;
    sx1     = over ? shifted : sx_s;
    sx2     = (sx1 < 0) ? '0 : sx1;
    ex_n    = ((sx_s < 0) ? len_s : sum) - signed'(PW'(1));
    ex_cap  = w_s - signed'(PW'(1));
    sy1     = (sy_s >= h_s) ? h_s - signed'(PW'(1)) : ((sy_s < 0) ? '0 : sy_s);
  end

  always_comb begin
    valid_nxt = valid_r;
    sx_nxt    = sx_r;
    ex_nxt    = ex_r;
    sy_nxt    = sy_r;
    color_nxt = color_r;
    last_nxt  = last_r;
    if (take) begin
      valid_nxt = 1'b1;
      sx_nxt    = sx2[CW-1:0];
      ex_nxt    = (over || (ex_n > ex_cap)) ? ex_cap[CW-1:0] : ex_n[CW-1:0];
      sy_nxt    = sy1[CW-1:0];
      color_nxt = span.color;
      last_nxt  = span.last;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r    <= sx_nxt;
    ex_r    <= ex_nxt;
    sy_r    <= sy_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_sx    = sx_r;
  assign out_ex    = ex_r;
  assign out_sy    = sy_r;
  assign out_color = color_r;
  assign out_last  = last_r;

endmodule

/* rtl/thick_line_span_rasterizer.sv */
// Thick line span rasterizer top level: front end, command queue, back end, clip stage.
// A span request passes the queue, the back end span register and the clip output register.
// Throughput: one item per cycle; every request while a line is active gives one span.
// Input stalls only when the QUEUE_DEPTH-entry command queue between front and back is full.
// Reset (rst_n low, synchronous) empties queue and pipeline, makes the block idle and
// sets screen width and height to 600 and 1024.
module thick_line_span_rasterizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [tlsr_pkg::COORD_W-1:0]    in_start_x,
  input  logic [tlsr_pkg::COORD_W-1:0]    in_start_y,
  input  logic [tlsr_pkg::COORD_W-1:0]    in_end_x,
  input  logic [tlsr_pkg::COORD_W-1:0]    in_end_y,
  input  logic [tlsr_pkg::RADIUS_W-1:0]   in_brush_radius,
  input  logic [tlsr_pkg::COLOR_W-1:0]    in_line_color,
  // span output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tlsr_pkg::COORD_W-1:0]    out_span_x_start,
  output logic [tlsr_pkg::COORD_W-1:0]    out_span_x_end,
  output logic [tlsr_pkg::COORD_W-1:0]    out_span_y,
  output logic [tlsr_pkg::COLOR_W-1:0]    out_span_color,
  output logic                            out_last_span,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlsr_pkg::SCREEN_W-1:0]   cfg_data
);

  logic [tlsr_pkg::SCREEN_W-1:0] scr_w_r, scr_w_nxt, scr_h_r, scr_h_nxt;

  tlsr_pkg::cmd_t       front_cmd, q_cmd;
  tlsr_pkg::q_stat_t    q_stat;
  tlsr_pkg::span_t      span;
  tlsr_pkg::back_stat_t back_stat;
  logic                 in_take, pop, span_valid, take;

  // Screen sizes are held already clamped to 1..4096
  function automatic logic [tlsr_pkg::SCREEN_W-1:0] clamp_screen(
    input logic [tlsr_pkg::SCREEN_W-1:0] v
  );
    logic [tlsr_pkg::SCREEN_W-1:0] r;
    if (v == '0) begin
      r = tlsr_pkg::SCREEN_W'(1);
    end else if (v > tlsr_pkg::SCREEN_MAX) begin
      r = tlsr_pkg::SCREEN_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlsr_pkg::REG_SCREEN_WIDTH:  scr_w_nxt = clamp_screen(cfg_data);
        tlsr_pkg::REG_SCREEN_HEIGHT: scr_h_nxt = clamp_screen(cfg_data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= tlsr_pkg::WIDTH_RESET;
      scr_h_r <= tlsr_pkg::HEIGHT_RESET;
    end else begin
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
    end
  end

  assign in_stall = q_stat.full;
  assign in_take  = in_valid && !in_stall;

  tlsr_front u_front (
    .action       (in_action),
    .start_x      (in_start_x),
    .start_y      (in_start_y),
    .end_x        (in_end_x),
    .end_y        (in_end_y),
    .brush_radius (in_brush_radius),
    .line_color   (in_line_color),
    .cmd          (front_cmd)
  );

  tlsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take),
    .wr_data (front_cmd),
    .rd_en   (pop),
    .rd_data (q_cmd),
    .stat    (q_stat)
  );

  tlsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .cmd        (q_cmd),
    .take       (take),
    .pop        (pop),
    .span_valid (span_valid),
    .span       (span),
    .stat       (back_stat)
  );

  tlsr_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_valid (span_valid),
    .span       (span),
    .scr_w      (scr_w_r),
    .scr_h      (scr_h_r),
    .take       (take),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sx     (out_span_x_start),
    .out_ex     (out_span_x_end),
    .out_sy     (out_span_y),
    .out_color  (out_span_color),
    .out_last   (out_last_span)
  );

  // Checks
  `include "thick_line_span_rasterizer_assert.svh"

  `TLSR_ASSERT_NEXT(a_span_held, span_valid && out_valid && out_stall, span_valid, "span lost while output stalled")
  `TLSR_ASSERT_NEXT(a_span_moves, span_valid && !(out_valid && out_stall), out_valid, "span not moved to output")
  `TLSR_ASSERT_NEXT(a_last_idles, back_stat.load && back_stat.load_last, !back_stat.busy, "still busy after last span")
  `TLSR_ASSERT_SAME(a_span_order, out_valid, out_span_x_start <= out_span_x_end, "span start past its end")

endmodule

/* bench/thick_line_span_rasterizer_tb.sv */
// Self-checking testbench for the thick line span rasterizer: directed table, then random lines.
`timescale 1ns / 1ps

module thick_line_span_rasterizer_tb;

  localparam int DIR_ROWS        = 25;
  localparam int PHASE_ITEMS     = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int QUIET_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;

  // One input item
  typedef struct packed {
    logic                          action;
    logic [tlsr_pkg::COORD_W-1:0]  x1;
    logic [tlsr_pkg::COORD_W-1:0]  y1;
    logic [tlsr_pkg::COORD_W-1:0]  x2;
    logic [tlsr_pkg::COORD_W-1:0]  y2;
    logic [tlsr_pkg::RADIUS_W-1:0] radius;
    logic [tlsr_pkg::COLOR_W-1:0]  color;
  } line_cmd_t;

  // One clipped span as seen on out_*
  typedef struct packed {
    logic [tlsr_pkg::COORD_W-1:0] x_start;
    logic [tlsr_pkg::COORD_W-1:0] x_end;
    logic [tlsr_pkg::COORD_W-1:0] y;
    logic [tlsr_pkg::COLOR_W-1:0] color;
    logic                         last;
  } fill_span_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_SPAN
  } row_chk_t;

  typedef struct packed {
    line_cmd_t  cmd;
    row_chk_t   chk;
    fill_span_t lit;
  } stim_row_t;

  localparam line_cmd_t REQ_LO = '{tlsr_pkg::ACT_NEXT, 12'h000, 12'h000, 12'h000, 12'h000,
                                   8'h00, 32'h0};
  localparam line_cmd_t REQ_HI = '{tlsr_pkg::ACT_NEXT, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                                   8'hFF, 32'hFFFF_FFFF};

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // request straight after reset: idle, nothing comes back
    '{REQ_LO, CHK_NONE, '0},
    // one-point line with radius 1: two spans, then done
    '{'{tlsr_pkg::ACT_START, 12'd100, 12'd100, 12'd100, 12'd100, 8'd1, 32'hFFFF_FFFF},
      CHK_NONE, '0},
    '{REQ_HI, CHK_SPAN, '{12'd99, 12'd100, 12'd100, 32'hFFFF_FFFF, 1'b0}},
    '{REQ_LO, CHK_SPAN, '{12'd99, 12'd100, 12'd100, 32'hFFFF_FFFF, 1'b1}},
    '{REQ_HI, CHK_NONE, '0},
    // zero radius is refused
    '{'{tlsr_pkg::ACT_START, 12'd10, 12'd10, 12'd20, 12'd20, 8'd0, 32'h0000_0001},
      CHK_NONE, '0},
    '{REQ_LO, CHK_NONE, '0},
    // start column below radius is refused
    '{'{tlsr_pkg::ACT_START, 12'd4, 12'd50, 12'd60, 12'd50, 8'd5, 32'h0000_0002},
      CHK_NONE, '0},
    '{REQ_HI, CHK_NONE, '0},
    // end row below radius is refused
    '{'{tlsr_pkg::ACT_START, 12'd50, 12'd50, 12'd50, 12'd4, 8'd5, 32'h0000_0003},
      CHK_NONE, '0},
    '{REQ_LO, CHK_NONE, '0},
    // coordinates equal to radius: span reaches column 0
    '{'{tlsr_pkg::ACT_START, 12'd10, 12'd10, 12'd10, 12'd10, 8'd10, 32'h0000_0000},
      CHK_NONE, '0},
    '{REQ_HI, CHK_SPAN, '{12'd0, 12'd19, 12'd10, 32'h0000_0000, 1'b0}},
    '{REQ_LO, CHK_MODEL, '0},
    // right and bottom edge clipping at the reset screen size
    '{'{tlsr_pkg::ACT_START, 12'd597, 12'd1022, 12'd590, 12'd1015, 8'd4, 32'h1234_5678},
      CHK_NONE, '0},
    '{REQ_HI, CHK_MODEL, '0},
    '{REQ_LO, CHK_MODEL, '0},
    '{REQ_HI, CHK_MODEL, '0},
    // largest coordinates and radius, very long line
    '{'{tlsr_pkg::ACT_START, 12'd4095, 12'd4095, 12'd255, 12'd255, 8'd255, 32'hA5A5_A5A5},
      CHK_NONE, '0},
    '{REQ_LO, CHK_MODEL, '0},
    '{REQ_HI, CHK_MODEL, '0},
    // new line while busy: steep, x stepping down
    '{'{tlsr_pkg::ACT_START, 12'd40, 12'd20, 12'd30, 12'd40, 8'd2, 32'h0F0F_0F0F},
      CHK_NONE, '0},
    '{REQ_LO, CHK_MODEL, '0},
    '{REQ_HI, CHK_MODEL, '0},
    '{REQ_LO, CHK_MODEL, '0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_action;
  logic [tlsr_pkg::COORD_W-1:0]   in_start_x;
  logic [tlsr_pkg::COORD_W-1:0]   in_start_y;
  logic [tlsr_pkg::COORD_W-1:0]   in_end_x;
  logic [tlsr_pkg::COORD_W-1:0]   in_end_y;
  logic [tlsr_pkg::RADIUS_W-1:0]  in_brush_radius;
  logic [tlsr_pkg::COLOR_W-1:0]   in_line_color;
  logic                           out_valid;
  logic                           out_stall;
  logic [tlsr_pkg::COORD_W-1:0]   out_span_x_start;
  logic [tlsr_pkg::COORD_W-1:0]   out_span_x_end;
  logic [tlsr_pkg::COORD_W-1:0]   out_span_y;
  logic [tlsr_pkg::COLOR_W-1:0]   out_span_color;
  logic                           out_last_span;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tlsr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tlsr_pkg::SCREEN_W-1:0]  cfg_data;

  // Predicted spans, oldest first
  fill_span_t span_q [$];
  int         fail_count;
  int         quiet_cycles;
  bit         calm;
  bit         hold_off_req;

  // Predictor state: line walker, circle stamp, screen size
  bit                            ln_busy;
  int                            pt_x, pt_y, ln_err, ln_steps, d_maj, d_min;
  bit                            maj_x;
  bit [1:0]                      dirs;     // bit0 x steps down, bit1 y steps down
  int                            cx, cy, c_err, slot, brush_r;
  logic [tlsr_pkg::COLOR_W-1:0]  brush_color;
  logic [tlsr_pkg::SCREEN_W-1:0] scr_w, scr_h;

  thick_line_span_rasterizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_brush_radius  (in_brush_radius),
    .in_line_color    (in_line_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_x_start (out_span_x_start),
    .out_span_x_end   (out_span_x_end),
    .out_span_y       (out_span_y),
    .out_span_color   (out_span_color),
    .out_last_span    (out_last_span),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Register value as used by the clip logic
  function automatic int screen_dim(logic [tlsr_pkg::SCREEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > tlsr_pkg::SCREEN_MAX) return int'(tlsr_pkg::SCREEN_MAX);
    return int'(v);
  endfunction

  function automatic int row_len();
    return slot[0] ? 2 * cy : 2 * cx;
  endfunction

  function automatic void stamp_circle();
    cx    = brush_r;
    cy    = 0;
    c_err = 1 - brush_r;
    slot  = 0;
  endfunction

  // Move to the next span slot; next circle row; next line point
  function automatic void advance_span();
    int sxs, sys;
    bit minor;
    slot++;
    if (slot < 4) return;
    slot = 0;
    cy++;
    if (c_err < 0) begin
      c_err += 2 * cy + 1;
    end else begin
      cx--;
      c_err += 2 * (cy - cx + 1);
    end
    if (cx >= cy) return;
    if (ln_steps <= 0) begin
      ln_busy = 1'b0;
      return;
    end
    sxs = dirs[0] ? -1 : 1;
    sys = dirs[1] ? -1 : 1;
    if (ln_err <= 0) begin
      ln_err += 2 * d_min;
      minor = 1'b0;
    end else begin
      ln_err += 2 * (d_min - d_maj);
      minor = 1'b1;
    end
    if (maj_x) begin
      pt_x += sxs;
      if (minor) pt_y += sys;
    end else begin
      pt_y += sys;
      if (minor) pt_x += sxs;
    end
    ln_steps--;
    stamp_circle();
  endfunction

  function automatic void skip_empty_rows();
    while (ln_busy && row_len() == 0) advance_span();
  endfunction

  // Update the predictor for one accepted item; returns 1 when a span is due
  function automatic bit predict_item(input line_cmd_t c, output fill_span_t s);
    int x1, y1, x2, y2, r, dx, dy, w, h, len, sx, sy, ex;
    s = '0;
    if (c.action == tlsr_pkg::ACT_START) begin
      x1 = int'(c.x1);
      y1 = int'(c.y1);
      x2 = int'(c.x2);
      y2 = int'(c.y2);
      r  = int'(c.radius);
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      ln_busy     = 1'b0;
      brush_r     = r;
      brush_color = c.color;
      if (r == 0 || x1 < r || x2 < r || y1 < r || y2 < r) return 1'b0;
      pt_x     = x1;
      pt_y     = y1;
      dirs     = {y2 <= y1, x2 <= x1};
      maj_x    = (dx >= dy);
      d_maj    = maj_x ? dx : dy;
      d_min    = maj_x ? dy : dx;
      ln_err   = 2 * d_min - d_maj;
      ln_steps = d_maj;
      stamp_circle();
      ln_busy = 1'b1;
      skip_empty_rows();
      return 1'b0;
    end
    if (!ln_busy) return 1'b0;

    // place the span of the current slot, then clip
    w   = screen_dim(scr_w);
    h   = screen_dim(scr_h);
    len = row_len();
    case (slot)
      0: begin sx = pt_x - cx; sy = pt_y + cy; end
      1: begin sx = pt_x - cy; sy = pt_y - cx; end
      2: begin sx = pt_x - cx; sy = pt_y - cy; end
      default: begin sx = pt_x - cy; sy = pt_y + cx; end
    endcase
    if (sx + len - 1 >= w) sx = w - len;
    if (sx < 0) sx = 0;
    ex = sx + len - 1;
    if (ex > w - 1) ex = w - 1;
    if (sy >= h) sy = h - 1;
    if (sy < 0) sy = 0;

    advance_span();
    skip_empty_rows();

    s.x_start = tlsr_pkg::COORD_W'(sx);
    s.x_end   = tlsr_pkg::COORD_W'(ex);
    s.y       = tlsr_pkg::COORD_W'(sy);
    s.color   = brush_color;
    s.last    = !ln_busy;
    return 1'b1;
  endfunction

  function automatic logic [tlsr_pkg::COORD_W-1:0] fit_coord(int v, int r);
    if (v < r) v = r;
    if (v > 4095) v = 4095;
    return tlsr_pkg::COORD_W'(v);
  endfunction

  // Coordinate near the far screen edge, near the radius, or anywhere
  function automatic logic [tlsr_pkg::COORD_W-1:0] pick_coord(int r, int lim);
    case ($urandom_range(0, 2))
      0: return fit_coord(lim - 6 + int'($urandom_range(0, 10)), r);
      1: return fit_coord(r + int'($urandom_range(0, 6)), r);
      default: return fit_coord(int'($urandom_range(0, 4095)), r);
    endcase
  endfunction

  // Random item: requests while a line runs, mostly short valid lines while idle
  function automatic line_cmd_t draw_item();
    line_cmd_t c;
    int        k, r;
    c.action = tlsr_pkg::ACT_NEXT;
    c.x1     = tlsr_pkg::COORD_W'($urandom);
    c.y1     = tlsr_pkg::COORD_W'($urandom);
    c.x2     = tlsr_pkg::COORD_W'($urandom);
    c.y2     = tlsr_pkg::COORD_W'($urandom);
    c.radius = tlsr_pkg::RADIUS_W'($urandom);
    c.color  = $urandom;
    k = int'($urandom_range(0, 99));
    if (ln_busy ? (k >= 3) : (k >= 80)) return c;
    c.action = tlsr_pkg::ACT_START;
    k = int'($urandom_range(0, 99));
    if (k < 25) return c;
    if (k < 30) begin
      r    = int'($urandom_range(100, 255));
      c.x1 = tlsr_pkg::COORD_W'($urandom_range(r, 4095));
      c.y1 = tlsr_pkg::COORD_W'($urandom_range(r, 4095));
      c.x2 = tlsr_pkg::COORD_W'($urandom_range(r, 4095));
      c.y2 = tlsr_pkg::COORD_W'($urandom_range(r, 4095));
    end else begin
      r    = int'($urandom_range(1, 3));
      c.x1 = pick_coord(r, screen_dim(scr_w));
      c.y1 = pick_coord(r, screen_dim(scr_h));
      c.x2 = fit_coord(int'(c.x1) + int'($urandom_range(0, 8)) - 4, r);
      c.y2 = fit_coord(int'(c.y1) + int'($urandom_range(0, 8)) - 4, r);
    end
    c.radius = tlsr_pkg::RADIUS_W'(r);
    return c;
  endfunction

  // Drive one item after a random gap; returns at the edge it is taken
  task automatic offer_item(input line_cmd_t c);
    int gap;
    gap = (calm || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= c.action;
    in_start_x      <= c.x1;
    in_start_y      <= c.y1;
    in_end_x        <= c.x2;
    in_end_y        <= c.y2;
    in_brush_radius <= c.radius;
    in_line_color   <= c.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random items until enough of them mattered to the block
  task automatic run_phase(input int n_items);
    line_cmd_t  c;
    fill_span_t s;
    int         done;
    done = 0;
    while (done < n_items) begin
      c = draw_item();
      offer_item(c);
      if (predict_item(c, s)) begin
        span_q.push_back(s);
        done++;
      end else if (c.action == tlsr_pkg::ACT_START) begin
        done++;
      end
    end
  endtask

  // Stop offering, wait for every predicted span, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(input logic [tlsr_pkg::SCREEN_W-1:0] w,
                              input logic [tlsr_pkg::SCREEN_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= tlsr_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_w = w;
    cfg_index <= tlsr_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_h = h;
    cfg_valid <= 1'b0;
  endtask

  // Stimulus and phase sequencing
  initial begin : stimulus
    fill_span_t sp;
    bit         got;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= tlsr_pkg::ACT_NEXT;
    in_start_x      <= '0;
    in_start_y      <= '0;
    in_end_x        <= '0;
    in_end_y        <= '0;
    in_brush_radius <= '0;
    in_line_color   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= tlsr_pkg::REG_SCREEN_WIDTH;
    cfg_data        <= '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    fail_count   = 0;
    ln_busy  = 1'b0;
    pt_x     = 0;
    pt_y     = 0;
    ln_err   = 0;
    ln_steps = 0;
    d_maj    = 0;
    d_min    = 0;
    maj_x    = 1'b0;
    dirs     = '0;
    cx       = 0;
    cy       = 0;
    c_err    = 0;
    slot     = 0;
    brush_r  = 0;
    brush_color = '0;
    scr_w    = tlsr_pkg::WIDTH_RESET;
    scr_h    = tlsr_pkg::HEIGHT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset screen size
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_item(DIR_TABLE[i].cmd);
      got = predict_item(DIR_TABLE[i].cmd, sp);
      if (DIR_TABLE[i].chk == CHK_SPAN) span_q.push_back(DIR_TABLE[i].lit);
      else if (DIR_TABLE[i].chk == CHK_MODEL && got) span_q.push_back(sp);
    end
    run_phase(PHASE_ITEMS);

    // largest screen
    drain();
    write_screen(tlsr_pkg::SCREEN_MAX, tlsr_pkg::SCREEN_MAX);
    run_phase(PHASE_ITEMS);

    // one-pixel screen
    drain();
    write_screen(13'd1, 13'd1);
    run_phase(PHASE_ITEMS);

    // out-of-range values clamp to 1 and 4096
    drain();
    write_screen(13'd0, 13'h1FFF);
    run_phase(PHASE_ITEMS);

    // random size, with a long output hold-off to back up the queue
    drain();
    write_screen(tlsr_pkg::SCREEN_W'($urandom_range(1, 4096)),
                 tlsr_pkg::SCREEN_W'($urandom_range(1, 4096)));
    hold_off_req = 1'b1;
    run_phase(PHASE_ITEMS);

    // raw random register values, no idling on either side
    drain();
    write_screen(tlsr_pkg::SCREEN_W'($urandom), tlsr_pkg::SCREEN_W'($urandom));
    calm = 1'b1;
    run_phase(PHASE_ITEMS);

    drain();
    if (fail_count == 0) begin
      $display("thick_line_span_rasterizer verification clean");
    end else begin
      $display("thick_line_span_rasterizer verification failed");
    end
    $finish;
  end

  // Span sink: random stall before each item, one long hold-off on request
  initial begin : span_sink
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else if (calm || $urandom_range(0, 3) == 0) begin
        gap = 0;
      end else begin
        gap = int'($urandom_range(0, 10));
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each delivered span with the oldest prediction
  always @(posedge clk) begin
    fill_span_t exp_span;
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected span: x %0d..%0d y %0d color %h last %0d",
                   out_span_x_start, out_span_x_end, out_span_y, out_span_color,
                   out_last_span);
      end else begin
        exp_span = span_q.pop_front();
        if (exp_span.x_start !== out_span_x_start || exp_span.x_end !== out_span_x_end ||
            exp_span.y !== out_span_y || exp_span.color !== out_span_color ||
            exp_span.last !== out_last_span) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"span mismatch: exp x %0d..%0d y %0d color %h last %0d, ",
                      "got x %0d..%0d y %0d color %h last %0d"},
                     exp_span.x_start, exp_span.x_end, exp_span.y, exp_span.color,
                     exp_span.last, out_span_x_start, out_span_x_end, out_span_y,
                     out_span_color, out_last_span);
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("thick_line_span_rasterizer verification failed");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tlsr_pkg.sv
rtl/tlsr_front.sv
rtl/tlsr_queue.sv
rtl/tlsr_back.sv
rtl/tlsr_clip.sv
rtl/thick_line_span_rasterizer.sv
bench/thick_line_span_rasterizer_tb.sv
